>>> hw/rtl/pda_pkg.sv
// ============================================================================
// pda_pkg
// Shared widths, register indexes and the configuration bundle of the PID
// controller with deadband and anti-windup.
// ============================================================================
package pda_pkg;

    localparam int INTEGRAL_WIDTH_DEF = 48;
    localparam int GAIN_W             = 24;
    localparam int LIM_W              = 16;
    localparam int DB_W               = 31;
    localparam int ERR_W              = 32;
    localparam int DIFF_W             = ERR_W + 1;
    localparam int DRV_W              = 17;
    localparam int FRAC_W             = 32;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 31;
    localparam int PKE_W              = GAIN_W + 1 + ERR_W;
    localparam int PKD_W              = GAIN_W + 1 + DIFF_W;
    localparam int ACC_HEAD           = 26;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KP  = 3'd0;
    localparam t_cfg_idx CFG_KI  = 3'd1;
    localparam t_cfg_idx CFG_KD  = 3'd2;
    localparam t_cfg_idx CFG_LIM = 3'd3;
    localparam t_cfg_idx CFG_DB  = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]  lim;
        logic [DB_W-1:0]   db;
    } t_cfg;

endpackage

>>> hw/rtl/pid_deadband_antiwindup.sv
// ============================================================================
// pid_deadband_antiwindup
// PID position controller with deadband and conditional-integration
// anti-windup; configuration registers and the two pipeline sections.
// ============================================================================
// Takes one signed Q16.16 error per transfer and returns one clamped integer
// drive per transfer, in order. One item is accepted every clock cycle while
// the output is not stalled and the input is not held off; each error passes
// the input register with the difference, then the gain products, then their
// partial sum, and the integrator loop stage then loads the result register.
// The integrator loop stage keeps the product of the integral gain and the
// error sum, so after a write of the integral gain the input is held off while
// that product is rebuilt. Registers are to be written by the user only while
// the block is idle; the block itself does not enforce this.
module pid_deadband_antiwindup import pda_pkg::*; #(
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [ERR_W-1:0] i_error,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [DRV_W-1:0] o_drive
);

    localparam int AW = INTEGRAL_WIDTH + ACC_HEAD;

    t_cfg                    r_cfg;
    logic                    ki_wr, busy;
    logic                    mid_valid, mid_ready, mid_outside;
    logic signed [ERR_W-1:0] mid_err;
    logic signed [PKE_W-1:0] mid_pke;
    logic signed [AW-1:0]    mid_a;

    assign ki_wr = i_cfg_we && (i_cfg_idx == CFG_KI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp  <= '0;
            r_cfg.ki  <= '0;
            r_cfg.kd  <= '0;
            r_cfg.lim <= '1;
            r_cfg.db  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP:  r_cfg.kp  <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:  r_cfg.ki  <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:  r_cfg.kd  <= i_cfg_data[GAIN_W-1:0];
                CFG_LIM: r_cfg.lim <= i_cfg_data[LIM_W-1:0];
                CFG_DB:  r_cfg.db  <= i_cfg_data[DB_W-1:0];
                default: r_cfg     <= r_cfg;
            endcase
        end
    end

    pda_front #(
        .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_hold   (busy),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_error  (i_error),
        .o_valid  (mid_valid),
        .i_ready  (mid_ready),
        .o_err    (mid_err),
        .o_outside(mid_outside),
        .o_pke    (mid_pke),
        .o_a      (mid_a)
    );

    pda_loop #(
        .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
    ) u_loop (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_ki_wr  (ki_wr),
        .o_busy   (busy),
        .i_valid  (mid_valid),
        .o_ready  (mid_ready),
        .i_err    (mid_err),
        .i_outside(mid_outside),
        .i_pke    (mid_pke),
        .i_a      (mid_a),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_drive  (o_drive)
    );

endmodule

>>> hw/rtl/pda_front.sv
// ============================================================================
// pda_front
// Input register, difference, gain products, deadband test and partial sum:
// three pipeline stages ahead of the integrator loop.
// ============================================================================
module pda_front import pda_pkg::*; #(
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cfg                            i_cfg,
    input  logic                            i_hold,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [ERR_W-1:0]         i_error,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [ERR_W-1:0]         o_err,
    output logic                            o_outside,
    output logic signed [PKE_W-1:0]         o_pke,
    output logic signed [INTEGRAL_WIDTH+ACC_HEAD-1:0] o_a
);

    localparam int AW = INTEGRAL_WIDTH + ACC_HEAD;

    logic                     r_s1_v, r_s2_v, r_s3_v;
    logic                     adv1, adv2, adv3, accept;
    logic signed [ERR_W-1:0]  r_prev_e;
    logic signed [ERR_W-1:0]  r_s1_e, r_s2_e, r_s3_e;
    logic signed [DIFF_W-1:0] r_s1_diff, n_s1_diff;
    logic signed [PKE_W-1:0]  r_s2_pkp, n_s2_pkp, r_s2_pki, n_s2_pki, r_s3_pke;
    logic signed [PKD_W-1:0]  r_s2_pkd, n_s2_pkd;
    logic                     r_s2_out, n_s2_out, r_s3_out;
    logic [ERR_W-1:0]         emag;
    logic signed [AW-1:0]     r_s3_a, n_s3_a;

    assign adv3    = !r_s3_v || i_ready;
    assign adv2    = !r_s2_v || adv3;
    assign adv1    = !r_s1_v || adv2;
    assign o_ready = adv1 && !i_hold;
    assign accept  = i_valid && o_ready;

    assign n_s1_diff = DIFF_W'(i_error) - DIFF_W'(r_prev_e);

    assign n_s2_pkp = $signed({1'b0, i_cfg.kp}) * r_s1_e;
    assign n_s2_pki = $signed({1'b0, i_cfg.ki}) * r_s1_e;
    assign n_s2_pkd = $signed({1'b0, i_cfg.kd}) * r_s1_diff;
    assign emag     = r_s1_e[ERR_W-1] ? ERR_W'(~r_s1_e + 1'b1) : ERR_W'(r_s1_e);
    assign n_s2_out = emag > {1'b0, i_cfg.db};

    assign n_s3_a = AW'(r_s2_pkp) + AW'(r_s2_pkd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_prev_e <= '0;
        end else begin
            if (adv1) begin
                r_s1_v <= accept;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v;
            end
            if (adv3) begin
                r_s3_v <= r_s2_v;
            end
            if (accept) begin
                r_prev_e <= i_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_e    <= i_error;
            r_s1_diff <= n_s1_diff;
        end
        if (adv2 && r_s1_v) begin
            r_s2_e   <= r_s1_e;
            r_s2_pkp <= n_s2_pkp;
            r_s2_pki <= n_s2_pki;
            r_s2_pkd <= n_s2_pkd;
            r_s2_out <= n_s2_out;
        end
        if (adv3 && r_s2_v) begin
            r_s3_e   <= r_s2_e;
            r_s3_a   <= n_s3_a;
            r_s3_pke <= r_s2_pki;
            r_s3_out <= r_s2_out;
        end
    end

    assign o_valid   = r_s3_v;
    assign o_err     = r_s3_e;
    assign o_outside = r_s3_out;
    assign o_pke     = r_s3_pke;
    assign o_a       = r_s3_a;

endmodule

>>> hw/rtl/pda_loop.sv
// ============================================================================
// pda_loop
// Integrator loop: anti-windup decision, saturating error sum, stored
// integral product, final truncation and clamp, and the result register.
// ============================================================================
module pda_loop import pda_pkg::*; #(
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cfg                            i_cfg,
    input  logic                            i_ki_wr,
    output logic                            o_busy,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [ERR_W-1:0]         i_err,
    input  logic                            i_outside,
    input  logic signed [PKE_W-1:0]         i_pke,
    input  logic signed [INTEGRAL_WIDTH+ACC_HEAD-1:0] i_a,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [DRV_W-1:0]         o_drive
);

    localparam int W   = INTEGRAL_WIDTH;
    localparam int AW  = W + ACC_HEAD;
    localparam int QW  = AW - FRAC_W;
    localparam int HW  = W - FRAC_W;
    localparam int PHW = GAIN_W + 1 + HW;
    localparam int PLW = GAIN_W + FRAC_W;

    localparam logic signed [W-1:0] SUM_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SUM_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0]     r_sum, n_sum;
    logic signed [AW-1:0]    r_pi, n_pi, r_kmx, r_kmn;
    logic signed [DRV_W-1:0] r_prev_drive, r_drive, n_drive;
    logic                    r_out_v, r_rc_pend, r_rc_add;
    logic signed [PHW-1:0]   r_ph;
    logic [PLW-1:0]          r_pl;

    logic                    move, sat, same, integ, ovf;
    logic signed [DRV_W:0]   lim_s;
    logic [W:0]              sum_w;
    logic signed [AW-1:0]    pke_x, acc;
    logic [QW-1:0]           q, mag;
    logic                    frac_nz, neg, big;
    logic [LIM_W-1:0]        mag_c;

    assign o_ready = !r_out_v || i_ready;
    assign move    = i_valid && o_ready;
    assign o_busy  = r_rc_pend || r_rc_add;

    assign lim_s = $signed({2'b00, i_cfg.lim});
    assign sat   = (r_prev_drive == lim_s) || (r_prev_drive == -lim_s);
    assign same  = i_err[ERR_W-1] == r_sum[W-1];
    assign integ = i_outside && !(sat && same);
    assign sum_w = {r_sum[W-1], r_sum} + (W+1)'(i_err);
    assign ovf   = sum_w[W] != sum_w[W-1];
    assign pke_x = AW'(i_pke);

    always_comb begin
        n_sum = r_sum;
        n_pi  = r_pi;
        acc   = i_a + r_pi;
        if (integ) begin
            priority if (ovf && !sum_w[W]) begin
                n_sum = SUM_MAX;
                n_pi  = r_kmx;
                acc   = i_a + r_kmx;
            end else if (ovf) begin
                n_sum = SUM_MIN;
                n_pi  = r_kmn;
                acc   = i_a + r_kmn;
            end else begin
                n_sum = sum_w[W-1:0];
                n_pi  = r_pi + pke_x;
                acc   = i_a + r_pi + pke_x;
            end
        end
    end

    assign q       = acc[AW-1:FRAC_W];
    assign frac_nz = |acc[FRAC_W-1:0];
    assign neg     = acc[AW-1];
    assign mag     = neg ? (~q + QW'(!frac_nz)) : q;
    assign big     = mag > QW'(i_cfg.lim);
    assign mag_c   = big ? i_cfg.lim : mag[LIM_W-1:0];

    always_comb begin
        if (!i_outside) begin
            n_drive = '0;
        end else if (neg) begin
            n_drive = -$signed({1'b0, mag_c});
        end else begin
            n_drive = $signed({1'b0, mag_c});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_pi         <= '0;
            r_kmx        <= '0;
            r_kmn        <= '0;
            r_prev_drive <= '0;
            r_out_v      <= 1'b0;
            r_rc_pend    <= 1'b0;
            r_rc_add     <= 1'b0;
        end else begin
            r_rc_pend <= i_ki_wr;
            r_rc_add  <= r_rc_pend;
            if (r_rc_pend) begin
                r_kmx <= (AW'(i_cfg.ki) <<< (W-1)) - AW'(i_cfg.ki);
                r_kmn <= -(AW'(i_cfg.ki) <<< (W-1));
            end
            if (r_rc_add) begin
                r_pi <= (AW'(r_ph) <<< FRAC_W) + AW'(r_pl);
            end else if (move) begin
                r_pi <= n_pi;
            end
            if (move) begin
                r_sum        <= n_sum;
                r_prev_drive <= n_drive;
                r_out_v      <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rc_pend) begin
            r_ph <= $signed({1'b0, i_cfg.ki}) * $signed(r_sum[W-1:FRAC_W]);
            r_pl <= i_cfg.ki * r_sum[FRAC_W-1:0];
        end
        if (move) begin
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_out_v;
    assign o_drive = r_drive;

    a_deadband_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && move && !i_outside |=> r_drive == '0)
        else $error("drive not zero inside deadband");

    a_deadband_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && move && !i_outside |=> r_sum == $past(r_sum))
        else $error("error sum changed inside deadband");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && move |=> (r_drive <= $past(lim_s)) && (r_drive >= -$past(lim_s)))
        else $error("drive beyond saturation limit");

    a_sum_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && move && integ && ovf && !sum_w[W] |=> r_sum == SUM_MAX)
        else $error("error sum did not saturate high");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of pid_deadband_antiwindup
// Drives position errors and configuration writes into the PID controller,
// predicts every drive with an independent fixed-point calculation and checks
// each result in order, under random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb;
    import pda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RX_HOLD_CYCLES = 120;
    localparam int  SWEEP_ITEMS    = 16;
    localparam real RUN_LIMIT_NS   = 2_000_000.0;

    class pid_drive_calc;
        logic [GAIN_W-1:0]       kp;
        logic [GAIN_W-1:0]       ki;
        logic [GAIN_W-1:0]       kd;
        logic [LIM_W-1:0]        lim;
        logic [DB_W-1:0]         db;
        longint                  err_sum;
        longint                  last_err;
        int                      last_drive;
        logic signed [DRV_W-1:0] pending_drives[$];
        int                      n_items;
        int                      n_deadband;
        int                      n_clamped;
        int                      n_frozen;
        int                      n_checked;
        int                      n_bad;

        function new();
            kp         = '0;
            ki         = '0;
            kd         = '0;
            lim        = '1;
            db         = '0;
            err_sum    = 0;
            last_err   = 0;
            last_drive = 0;
            n_items    = 0;
            n_deadband = 0;
            n_clamped  = 0;
            n_frozen   = 0;
            n_checked  = 0;
            n_bad      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KP:  kp  = data[GAIN_W-1:0];
                CFG_KI:  ki  = data[GAIN_W-1:0];
                CFG_KD:  kd  = data[GAIN_W-1:0];
                CFG_LIM: lim = data[LIM_W-1:0];
                CFG_DB:  db  = data[DB_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_error(logic signed [ERR_W-1:0] e);
            longint               ev;
            longint               emag;
            longint               top;
            bit                   railed;
            logic signed [127:0]  p_gain;
            logic signed [127:0]  i_gain;
            logic signed [127:0]  d_gain;
            logic signed [127:0]  xe;
            logic signed [127:0]  xs;
            logic signed [127:0]  xd;
            logic signed [127:0]  acc;
            logic [127:0]         whole;
            int                   drv;
            ev   = e;
            emag = (ev < 0) ? -ev : ev;
            drv  = 0;
            n_items++;
            if (emag <= longint'(db)) begin
                n_deadband++;
            end else begin
                railed = (last_drive == int'(lim)) || (-last_drive == int'(lim));
                if (railed && ((ev >= 0) == (err_sum >= 0))) begin
                    n_frozen++;
                end else begin
                    top = (longint'(1) <<< (INTEGRAL_WIDTH_DEF - 1)) - 1;
                    err_sum += ev;
                    if (err_sum > top) begin
                        err_sum = top;
                    end else if (err_sum < -top - 1) begin
                        err_sum = -top - 1;
                    end
                end
                p_gain = kp;
                i_gain = ki;
                d_gain = kd;
                xe     = ev;
                xs     = err_sum;
                xd     = ev - last_err;
                acc    = p_gain * xe + i_gain * xs + d_gain * xd;
                whole  = (acc < 0) ? -acc : acc;
                whole  = whole >> FRAC_W;
                if (whole > lim) begin
                    whole = lim;
                    n_clamped++;
                end
                drv = int'(whole[DRV_W-1:0]);
                if (acc < 0) begin
                    drv = -drv;
                end
            end
            last_drive = drv;
            last_err   = ev;
            pending_drives.push_back(DRV_W'(drv));
        endfunction

        task report(string msg);
            n_bad++;
            if (n_bad <= 40) begin
                $display("MISMATCH: %s", msg);
            end
        endtask

        task check_drive(logic signed [DRV_W-1:0] got);
            logic signed [DRV_W-1:0] want;
            if (pending_drives.size() == 0) begin
                report($sformatf("drive %0d arrived with nothing pending", got));
            end else begin
                want = pending_drives.pop_front();
                n_checked++;
                if (got !== want) begin
                    report($sformatf("drive %0d, expected %0d (result %0d)",
                                     got, want, n_checked));
                end
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [ERR_W-1:0] i_error;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [DRV_W-1:0] o_drive;

    pid_drive_calc drive_calc;
    bit            tx_burst    = 1'b0;
    bit            rx_always   = 1'b0;
    bit            rx_hold_req = 1'b0;
    int            n_settings  = 0;

    pid_deadband_antiwindup dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_error     (i_error),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                drive_calc.note_error(i_error);
            end
            if (o_out_valid && i_out_ready) begin
                drive_calc.check_drive(o_drive);
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end else if (r < 60) begin
            return GAIN_W'($urandom_range(0, 1 << 17));
        end
        return GAIN_W'($urandom);
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 25) begin
            return '1;
        end else if (r < 65) begin
            return LIM_W'($urandom_range(1, 2000));
        end
        return LIM_W'($urandom);
    endfunction

    function automatic logic [DB_W-1:0] pick_deadband();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return '0;
        end else if (r < 30) begin
            return '1;
        end else if (r < 80) begin
            return DB_W'($urandom_range(0, 1 << 18));
        end
        return DB_W'($urandom);
    endfunction

    // Mostly runs of one sign with random size, as a loop settling on a
    // target would produce, mixed with deadband edges and extremes.
    function automatic logic signed [ERR_W-1:0] pick_error(logic [DB_W-1:0] db, int bias);
        int     r;
        bit     neg;
        longint m;
        r   = $urandom_range(0, 99);
        neg = (bias != 0 && $urandom_range(0, 3) != 0) ? (bias < 0) : bit'($urandom);
        if (r < 20) begin
            return ERR_W'($urandom);
        end else if (r < 45) begin
            m = $urandom_range(0, 1 << 20);
        end else if (r < 60) begin
            m = longint'(db) + int'($urandom_range(0, 4)) - 2;
            if (m < 0) begin
                m = 0;
            end else if (m > 64'sh7FFF_FFFF) begin
                m = 64'sh7FFF_FFFF;
            end
        end else if (r < 66) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return '0;
                default: m = 1;
            endcase
        end else begin
            m = $urandom_range(0, 1 << 26);
        end
        return ERR_W'(neg ? -m : m);
    endfunction

    task write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        drive_calc.set_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task set_config(input logic [GAIN_W-1:0] kp, ki, kd,
                    input logic [LIM_W-1:0] lim, input logic [DB_W-1:0] db);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(CFG_KP, {junk[CFG_DATA_W-1:GAIN_W], kp});
        junk = $urandom;
        write_reg(CFG_KI, {junk[CFG_DATA_W-1:GAIN_W], ki});
        junk = $urandom;
        write_reg(CFG_KD, {junk[CFG_DATA_W-1:GAIN_W], kd});
        junk = $urandom;
        write_reg(CFG_LIM, {junk[CFG_DATA_W-1:LIM_W], lim});
        write_reg(CFG_DB, db);
        n_settings++;
    endtask

    task poke_unused();
        for (int k = CFG_DB + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(t_cfg_idx'(k), CFG_DATA_W'($urandom));
        end
    endtask

    task send_error(logic signed [ERR_W-1:0] e);
        int gap;
        gap = tx_burst ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_error    <= e;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drive_calc.pending_drives.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int r;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_always) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_out_ready <= 1'b1;
                    n = $urandom_range(1, 12);
                end else if (r < 92) begin
                    i_out_ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_ready <= 1'b0;
                    n = $urandom_range(15, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int bias;
        drive_calc = new();
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_KP;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_error    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Deadband edges, truncation toward zero, clamping and frozen integration.
        set_config(24'h01_0000, 24'h00_0010, 24'h00_4000, 16'd1000, 31'h0001_0000);
        poke_unused();
        send_error('0);
        send_error(32'sh0001_0000);
        send_error(-32'sh0001_0000);
        send_error(32'sh0001_0001);
        send_error(-32'sh0001_0001);
        send_error(-32'sh0001_8000);
        send_error(32'sh7FFF_FFFF);
        send_error(32'sh7FFF_FFFF);
        send_error(32'sh8000_0000);
        send_error(32'sh8000_0000);
        send_error(32'sh0003_0000);
        drain();
        // A zero limit makes a zero drive count as railed.
        set_config(24'h01_0000, 24'h00_0010, 24'h00_4000, 16'd0, 31'd0);
        send_error(32'sh0002_0000);
        send_error(-32'sh0002_0000);
        send_error(32'sh0002_0000);
        drain();
        set_config('1, '1, '1, '1, '0);
        send_error(32'sh7FFF_FFFF);
        send_error(32'sh8000_0000);
        send_error(32'sh0000_0001);
        send_error(-32'sh0000_0001);
        drain();
        set_config('1, '1, '1, '1, '1);
        send_error(32'sh7FFF_FFFF);
        send_error(32'sh8000_0000);

        for (int p = 0; p < 6; p++) begin
            drain();
            set_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_deadband());
            if ($urandom_range(0, 1) == 1) begin
                poke_unused();
            end
            bias = 0;
            for (int k = 0; k < 130; k++) begin
                if (k % 16 == 0) begin
                    bias = int'($urandom_range(0, 2)) - 1;
                end
                if (p == 2 && k == 40) begin
                    rx_hold_req = 1'b1;
                    tx_burst    = 1'b1;
                end
                if (p == 4 && k == 0) begin
                    tx_burst  = 1'b1;
                    rx_always = 1'b1;
                end
                if ((p == 2 && k == 100) || (p == 4 && k == 50)) begin
                    tx_burst  = 1'b0;
                    rx_always = 1'b0;
                end
                send_error(pick_error(drive_calc.db, bias));
            end
        end

        // Runs of extreme errors with a tiny integral gain; the drive then
        // follows the error sum as it swings from one sign to the other.
        drain();
        set_config('0, 24'h00_0001, '0, '1, '0);
        tx_burst  = 1'b1;
        rx_always = 1'b1;
        repeat (SWEEP_ITEMS) send_error(32'sh8000_0000);
        repeat (2 * SWEEP_ITEMS) send_error(32'sh7FFF_FFFF);
        repeat (5) send_error(-32'sh0100_0000);
        tx_burst  = 1'b0;
        rx_always = 1'b0;
        drain();

        $display("Covered %0d errors over %0d settings: %0d in the deadband, %0d clamped, %0d %s",
                 drive_calc.n_items, n_settings, drive_calc.n_deadband,
                 drive_calc.n_clamped, drive_calc.n_frozen, "with integration held.");
        $display("Checked %0d drives, %0d mismatches.", drive_calc.n_checked, drive_calc.n_bad);
        if (drive_calc.n_bad == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
